[rtl/sfrad_pkg.sv]
`default_nettype none
package sfrad_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 8192;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned VOL_W    = 8;
  localparam int unsigned THR_W    = 14;
  localparam int unsigned FILL_W   = 14;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Register reset values
  localparam logic [RATE_W-1:0] NATIVE_RATE_RST = 18'd66207;
  localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = 18'd48000;
  localparam logic [VOL_W-1:0]  VOLUME_RST      = 8'd100;
  localparam logic [THR_W-1:0]  START_THR_RST   = 14'd4096;
  localparam logic [THR_W-1:0]  STOP_THR_RST    = 14'd1024;

  // Divide by 100: q = (a * RECIP) >> DIV_SHIFT, exact for a < 2^23
  localparam int unsigned MUL_W     = 24;
  localparam int unsigned PROD_W    = 23;
  localparam int unsigned QUO_W     = 17;
  localparam int unsigned DIV_SHIFT = 30;
  localparam logic [MUL_W-1:0] RECIP = 24'd10737419;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NATIVE_RATE = 3'd0,
    REG_OUTPUT_RATE = 3'd1,
    REG_VOLUME      = 3'd2,
    REG_START_THR   = 3'd3,
    REG_STOP_THR    = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_GATE,
    ST_ACCUM,
    ST_POP,
    ST_SCALE,
    ST_WAIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } pair_t;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       block_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       push_accepted;
    logic [FILL_W-1:0]          fill_level;
    logic                       output_enabled;
    logic [CNT_W-1:0]           underrun_count;
  } out_item_t;

  typedef struct packed {
    logic  start;
    pair_t held;
  } scl_req_t;

  typedef struct packed {
    logic  done;
    pair_t result;
  } scl_rsp_t;

endpackage
`default_nettype wire

[rtl/sfrad_store.sv]
`default_nettype none
module sfrad_store #(
  parameter int unsigned DEPTH = sfrad_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire sfrad_pkg::pair_t wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output sfrad_pkg::pair_t      rdata_o
);

  sfrad_pkg::pair_t mem [DEPTH];
  sfrad_pkg::pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/sfrad_scaler.sv]
`default_nettype none
module sfrad_scaler (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sfrad_pkg::scl_req_t   req_i,
  input  wire logic [sfrad_pkg::VOL_W-1:0] volume_i,
  output sfrad_pkg::scl_rsp_t        rsp_o
);

  // step: 0 mul left, 1 div left, 2 mul right, 3 div right
  logic [1:0]                        step_q;
  logic                              busy_q;
  logic                              done_q;
  logic [sfrad_pkg::PROD_W-1:0]      prod_q;
  logic                              neg_q;
  sfrad_pkg::pair_t                  result_q;

  logic signed [sfrad_pkg::SAMPLE_W-1:0] sample;
  logic [sfrad_pkg::SAMPLE_W:0]          mag;
  logic [sfrad_pkg::MUL_W-1:0]           mul_a;
  logic [sfrad_pkg::MUL_W-1:0]           mul_b;
  logic [2*sfrad_pkg::MUL_W-1:0]         mul_p;
  logic [sfrad_pkg::QUO_W-1:0]           quo;
  logic [sfrad_pkg::QUO_W-1:0]           quo_neg;
  logic [sfrad_pkg::SAMPLE_W-1:0]        sat;

  always_comb begin
    sample = step_q[1] ? req_i.held.right : req_i.held.left;
    mag    = sample[sfrad_pkg::SAMPLE_W-1] ?
             (~{sample[sfrad_pkg::SAMPLE_W-1], sample} + 17'd1) :
             {sample[sfrad_pkg::SAMPLE_W-1], sample};
    // one shared multiplier: |x|*volume, then product*reciprocal
    if (step_q[0]) begin
      mul_a = {1'b0, prod_q};
      mul_b = sfrad_pkg::RECIP;
    end else begin
      mul_a = {7'd0, mag};
      mul_b = {16'd0, volume_i};
    end
    mul_p   = mul_a * mul_b;
    quo     = mul_p[sfrad_pkg::DIV_SHIFT +: sfrad_pkg::QUO_W];
    quo_neg = 17'd0 - quo;
    if (neg_q) begin
      sat = (quo > 17'd32768) ? 16'h8000 : quo_neg[sfrad_pkg::SAMPLE_W-1:0];
    end else begin
      sat = (quo > 17'd32767) ? 16'h7fff : quo[sfrad_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == 2'd3);
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (!step_q[0]) begin
        prod_q <= mul_p[sfrad_pkg::PROD_W-1:0];
        neg_q  <= sample[sfrad_pkg::SAMPLE_W-1];
      end else if (step_q[1]) begin
        result_q.right <= sat;
      end else begin
        result_q.left <= sat;
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("scaler done while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == 2'd3 && !req_i.start) |=> done_q)
    else $error("scaler finished without done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(req_i.start))
    else $error("scaler started without request");

endmodule
`default_nettype wire

[rtl/stereo_fifo_rate_adapting_drain_core.sv]
// Push or muted tick: the item goes from idle to the push or gate state, then to the response state.
// Live tick: the item goes through gate, accumulate, pop, scale, wait and response states; the pop
// loop reads one pair per cycle, then the shared multiplier does multiply and divide for each side and raises done.
// One item at a time: the next item is taken the cycle after the result loads; a stalled
// result holds the block in its response state. Reset (async, low) clears pointers, fill,
// phase, held pair, gating, counter and loads register defaults; the store is not cleared.
`default_nettype none
module stereo_fifo_rate_adapting_drain_core #(
  parameter int unsigned FIFO_DEPTH = sfrad_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire sfrad_pkg::in_item_t               in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output sfrad_pkg::out_item_t                   out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [sfrad_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sfrad_pkg::RATE_W-1:0]      cfg_data_i
);

  localparam int unsigned AW   = $clog2(FIFO_DEPTH);
  localparam int unsigned CW   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CMPW = (CW > sfrad_pkg::THR_W) ? CW : sfrad_pkg::THR_W;

  // configuration
  logic [sfrad_pkg::RATE_W-1:0] native_q;
  logic [sfrad_pkg::RATE_W-1:0] orate_q;
  logic [sfrad_pkg::VOL_W-1:0]  vol_q;
  logic [sfrad_pkg::THR_W-1:0]  start_thr_q;
  logic [sfrad_pkg::THR_W-1:0]  stop_thr_q;

  sfrad_pkg::state_e state_q, state_d;
  sfrad_pkg::in_item_t item_q;

  logic [AW-1:0]                wp_q, wp_d;
  logic [AW-1:0]                rp_q, rp_d;
  logic [CW-1:0]                fill_q, fill_d;
  logic [sfrad_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic                         en_q, en_d;
  logic                         muted_q, muted_d;
  logic [sfrad_pkg::CNT_W-1:0]  unders_q, unders_d;
  logic                         acc_q, acc_d;
  logic                         zero_q, zero_d;
  logic                         pop_q;
  sfrad_pkg::pair_t             held_q;

  logic                         out_valid_q, out_valid_d;
  sfrad_pkg::out_item_t         out_q, out_d;

  logic                         in_xfer;
  logic                         we;
  logic                         re;
  sfrad_pkg::pair_t             wdata;
  sfrad_pkg::pair_t             rdata;
  sfrad_pkg::scl_req_t          scl_req;
  sfrad_pkg::scl_rsp_t          scl_rsp;

  logic [AW-1:0]                wp_inc;
  logic [AW-1:0]                rp_inc;
  logic                         full;
  logic                         phase_ge;
  logic                         start_ok;
  logic                         below_stop;

  assign in_stall_o  = (state_q != sfrad_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      native_q    <= sfrad_pkg::NATIVE_RATE_RST;
      orate_q     <= sfrad_pkg::OUTPUT_RATE_RST;
      vol_q       <= sfrad_pkg::VOLUME_RST;
      start_thr_q <= sfrad_pkg::START_THR_RST;
      stop_thr_q  <= sfrad_pkg::STOP_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sfrad_pkg::REG_NATIVE_RATE: native_q    <= cfg_data_i;
        sfrad_pkg::REG_OUTPUT_RATE: orate_q     <= cfg_data_i;
        sfrad_pkg::REG_VOLUME:      vol_q       <= cfg_data_i[sfrad_pkg::VOL_W-1:0];
        sfrad_pkg::REG_START_THR:   start_thr_q <= cfg_data_i[sfrad_pkg::THR_W-1:0];
        sfrad_pkg::REG_STOP_THR:    stop_thr_q  <= cfg_data_i[sfrad_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign wp_inc     = (wp_q == AW'(FIFO_DEPTH - 1)) ? '0 : wp_q + AW'(1);
  assign rp_inc     = (rp_q == AW'(FIFO_DEPTH - 1)) ? '0 : rp_q + AW'(1);
  assign full       = (fill_q >= CW'(FIFO_DEPTH));
  assign phase_ge   = (phase_q >= {{(sfrad_pkg::PHASE_W - sfrad_pkg::RATE_W){1'b0}}, orate_q});
  assign start_ok   = (CMPW'(fill_q) >= CMPW'(start_thr_q));
  assign below_stop = (CMPW'(fill_q) < CMPW'(stop_thr_q));

  assign wdata.left  = item_q.left_in;
  assign wdata.right = item_q.right_in;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    fill_d      = fill_q;
    phase_d     = phase_q;
    en_d        = en_q;
    muted_d     = muted_q;
    unders_d    = unders_q;
    acc_d       = acc_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    re          = 1'b0;
    scl_req.start = 1'b0;
    scl_req.held  = held_q;

    unique case (state_q)
      sfrad_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = (in_data_i.command == sfrad_pkg::CMD_TICK) ?
                    sfrad_pkg::ST_GATE : sfrad_pkg::ST_PUSH;
        end
      end
      sfrad_pkg::ST_PUSH: begin
        zero_d = 1'b1;
        acc_d  = !full;
        if (!full) begin
          we     = 1'b1;
          wp_d   = wp_inc;
          fill_d = fill_q + CW'(1);
        end
        state_d = sfrad_pkg::ST_RESP;
      end
      sfrad_pkg::ST_GATE: begin
        acc_d = 1'b0;
        if (item_q.block_start) begin
          if (!en_q) begin
            if (start_ok) begin
              en_d    = 1'b1;
              muted_d = 1'b0;
            end else begin
              muted_d = 1'b1;
            end
          end else if (below_stop) begin
            en_d     = 1'b0;
            unders_d = unders_q + 32'd1;
            muted_d  = 1'b1;
          end else begin
            muted_d = 1'b0;
          end
        end
        zero_d  = muted_d;
        state_d = muted_d ? sfrad_pkg::ST_RESP : sfrad_pkg::ST_ACCUM;
      end
      sfrad_pkg::ST_ACCUM: begin
        phase_d = phase_q + {{(sfrad_pkg::PHASE_W - sfrad_pkg::RATE_W){1'b0}}, native_q};
        state_d = sfrad_pkg::ST_POP;
      end
      sfrad_pkg::ST_POP: begin
        // one pair per cycle; the exit cycle also lets the last read land in held_q
        if (!phase_ge) begin
          state_d = sfrad_pkg::ST_SCALE;
        end else if (fill_q == '0) begin
          en_d     = 1'b0;
          unders_d = unders_q + 32'd1;
          state_d  = sfrad_pkg::ST_SCALE;
        end else begin
          re      = 1'b1;
          rp_d    = rp_inc;
          fill_d  = fill_q - CW'(1);
          phase_d = phase_q - {{(sfrad_pkg::PHASE_W - sfrad_pkg::RATE_W){1'b0}}, orate_q};
        end
      end
      sfrad_pkg::ST_SCALE: begin
        scl_req.start = 1'b1;
        state_d       = sfrad_pkg::ST_WAIT;
      end
      sfrad_pkg::ST_WAIT: begin
        if (scl_rsp.done) begin
          state_d = sfrad_pkg::ST_RESP;
        end
      end
      sfrad_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.out_left       = zero_q ? '0 : scl_rsp.result.left;
          out_d.out_right      = zero_q ? '0 : scl_rsp.result.right;
          out_d.push_accepted  = acc_q;
          out_d.fill_level     = sfrad_pkg::FILL_W'(fill_q);
          out_d.output_enabled = en_q;
          out_d.underrun_count = unders_q;
          state_d              = sfrad_pkg::ST_IDLE;
        end
      end
      default: state_d = sfrad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfrad_pkg::ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      phase_q     <= '0;
      en_q        <= 1'b0;
      muted_q     <= 1'b0;
      unders_q    <= '0;
      acc_q       <= 1'b0;
      zero_q      <= 1'b0;
      pop_q       <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      phase_q     <= phase_d;
      en_q        <= en_d;
      muted_q     <= muted_d;
      unders_q    <= unders_d;
      acc_q       <= acc_d;
      zero_q      <= zero_d;
      pop_q       <= re;
      out_valid_q <= out_valid_d;
      if (pop_q) begin
        held_q <= rdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  sfrad_store #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  sfrad_scaler u_scaler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (scl_req),
    .volume_i (vol_q),
    .rsp_o    (scl_rsp)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(FIFO_DEPTH))
    else $error("fill above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == sfrad_pkg::ST_RESP))
    else $error("result loaded outside response state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sfrad_pkg::ST_PUSH && !full) |=> fill_q == $past(fill_q) + CW'(1))
    else $error("stored push did not raise fill");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_rsp.done |-> state_q == sfrad_pkg::ST_WAIT)
    else $error("scaler done outside wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> fill_q != '0)
    else $error("pop from empty store");

endmodule
`default_nettype wire
